FILE: rtl/bqmc_pkg.sv
// ----------------------------------------------------------------------------
// bqmc_pkg
// Shared types and constants for the multichannel transposed-form biquad.
// ----------------------------------------------------------------------------
package bqmc_pkg;

    localparam int COEF_W  = 32;  // Q8.24 coefficient width
    localparam int FRAC_W  = 24;  // fraction bits of coefficients and delay words
    localparam int STATE_W = 48;  // delay word width
    localparam int PROD_W  = 64;  // coefficient times sample
    localparam int ACC_W   = 66;  // exact sum of two products and a delay word
    localparam int CHAN_W  = 3;
    localparam int CFG_W   = 3;

    // register indexes on the configuration port
    localparam logic [CFG_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_W-1:0] REG_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] B0_RESET = 32'sh0100_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_B0,
        S_B1,
        S_Y,
        S_A1,
        S_R1,
        S_R2,
        S_D2
    } t_state;

endpackage

FILE: rtl/biquad_tdf2_multichannel.sv
// ----------------------------------------------------------------------------
// biquad_tdf2_multichannel
// Second-order IIR section, transposed direct form II, one delay pair per
// channel, with a single shared 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Input beats (i_valid / o_ready) carry a signed sample and a channel number;
// output beats (o_valid / i_ready) carry the filtered sample, saturated to
// SAMPLE_BITS, and the same channel number. Coefficients b0, b1, b2, a1, a2
// (signed Q8.24) are written through i_cfg_wr_en / i_cfg_index / i_cfg_data
// by the user only while the block is idle; the block does not enforce it.
// A filtered beat is loaded into the output register in the last step, S_D2,
// and no new input beat is taken until the sequencer is back in S_IDLE: six
// products run one after another through the shared multiplier (S_B0 to
// S_R2), then the output step. A channel number at or above CHANNELS passes
// the sample through unchanged, going from S_IDLE straight to S_D2.
// If the previous result is still held by the receiver, the sequencer waits
// in its last step until that beat leaves, and o_ready stays low meanwhile.
// Synchronous active-low reset returns the coefficients to passthrough
// (b0 = 1.0) and clears all delay words at once; no clearing pass.
// ----------------------------------------------------------------------------
module biquad_tdf2_multichannel
    import bqmc_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_wr_en,
    input  logic [CFG_W-1:0]              i_cfg_index,
    input  logic [COEF_W-1:0]             i_cfg_data,

    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [CHAN_W-1:0]             i_chan_in,

    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic [CHAN_W-1:0]             o_chan_out
);

    // only channel numbers below eight can ever be addressed
    localparam int DEPTH = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SH_W  = ACC_W - FRAC_W;

    localparam logic signed [SH_W-1:0] Y_MAX =
        {{(SH_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SH_W-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [ACC_W-1:0] ST_MAX =
        {{(ACC_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ST_MIN = ~ST_MAX;
    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W - FRAC_W){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};

    t_state r_state, n_state;

    logic signed [COEF_W-1:0]      r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [STATE_W-1:0]     r_d1 [DEPTH];
    logic signed [STATE_W-1:0]     r_d2 [DEPTH];

    logic signed [SAMPLE_BITS-1:0] r_x, r_y;
    logic [CHAN_W-1:0]             r_chan;
    logic                          r_bypass;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic [CHAN_W-1:0]             r_out_chan;

    logic signed [COEF_W-1:0]      mul_a;
    logic signed [COEF_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]      mul_p;
    logic                          in_beat;
    logic                          out_free;
    logic                          finish;
    logic [IDX_W-1:0]              idx;
    logic signed [SH_W-1:0]        y_sh;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic signed [ACC_W-1:0]       d2_sum;
    logic signed [STATE_W-1:0]     d1_sat, d2_sat;

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_chan_out   = r_out_chan;

    assign in_beat  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign finish   = (r_state == S_D2) && out_free;
    assign idx      = r_chan[IDX_W-1:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= B0_RESET;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_B0:  r_b0 <= i_cfg_data;
                REG_B1:  r_b1 <= i_cfg_data;
                REG_B2:  r_b2 <= i_cfg_data;
                REG_A1:  r_a1 <= i_cfg_data;
                REG_A2:  r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_state = (32'(i_chan_in) >= CHANNELS) ? S_D2 : S_B0;
                end
            end
            S_B0: n_state = S_B1;
            S_B1: n_state = S_Y;
            S_Y:  n_state = S_A1;
            S_A1: n_state = S_R1;
            S_R1: n_state = S_R2;
            S_R2: n_state = S_D2;
            S_D2: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = r_b2;
        mul_b = 32'(r_x);
        unique case (r_state)
            S_B0:    mul_a = r_b0;
            S_B1:    mul_a = r_b1;
            S_A1: begin
                mul_a = r_a1;
                mul_b = 32'(r_y);
            end
            S_R2: begin
                mul_a = r_a2;
                mul_b = 32'(r_y);
            end
            default: ;
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // round-half-up result, saturated to the sample width
    assign y_sh  = SH_W'(r_acc >>> FRAC_W);
    assign y_sat = (y_sh > Y_MAX) ? Y_MAX[SAMPLE_BITS-1:0] :
                   (y_sh < Y_MIN) ? Y_MIN[SAMPLE_BITS-1:0] :
                   y_sh[SAMPLE_BITS-1:0];

    assign d1_sat = (r_acc > ST_MAX) ? ST_MAX[STATE_W-1:0] :
                    (r_acc < ST_MIN) ? ST_MIN[STATE_W-1:0] :
                    r_acc[STATE_W-1:0];

    assign d2_sum = r_acc - ACC_W'(r_prod);
    assign d2_sat = (d2_sum > ST_MAX) ? ST_MAX[STATE_W-1:0] :
                    (d2_sum < ST_MIN) ? ST_MIN[STATE_W-1:0] :
                    d2_sum[STATE_W-1:0];

    // datapath: product, accumulator and item registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_x      <= i_sample_in;
            r_y      <= i_sample_in;
            r_chan   <= i_chan_in;
            r_bypass <= (32'(i_chan_in) >= CHANNELS);
        end
        if (r_state != S_IDLE && r_state != S_D2) begin
            r_prod <= mul_p;
        end
        unique case (r_state)
            S_B1:    r_acc <= ACC_W'(r_prod) + ACC_W'(r_d1[idx]) + HALF;
            S_Y: begin
                r_y   <= y_sat;
                r_acc <= ACC_W'(r_prod) + ACC_W'(r_d2[idx]);
            end
            S_R1:    r_acc <= r_acc - ACC_W'(r_prod);
            S_R2:    r_acc <= ACC_W'(r_prod);
            default: ;
        endcase
    end

    // per-channel delay words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_d1[i] <= '0;
                r_d2[i] <= '0;
            end
        end else begin
            if (r_state == S_R2) begin
                r_d1[idx] <= d1_sat;
            end
            if (finish && !r_bypass) begin
                r_d2[idx] <= d2_sat;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_sample <= r_y;
            r_out_chan   <= r_chan;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_ready)
        else $error("input taken again right after a beat");

    a_out_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_D2))
        else $error("result shown outside the last step");

    a_chan_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (o_chan_out == $past(r_chan)) && o_valid)
        else $error("channel number lost on the way out");

    a_bypass_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && r_bypass) |=> (o_sample_out == $past(r_x)))
        else $error("absent channel did not pass the sample through");
`endif

endmodule

FILE: bench/tb_biquad_tdf2_multichannel.sv
// ----------------------------------------------------------------------------
// tb_biquad_tdf2_multichannel
// Self-checking bench for the multichannel transposed-form biquad. A bit-true
// filter model tracks the coefficients and the delay pair of every channel,
// and predicts each filtered beat. Stimulus opens with passthrough extremes on
// every channel, then runs random samples under a series of coefficient sets:
// a typical lowpass, all-max, all-min, random, small random, zero and mixed
// extremes. Writes to unused register indexes are mixed in and must leave the
// filter alone. Both sides idle at random; the receiver twice holds off long.
// ----------------------------------------------------------------------------
module tb_biquad_tdf2_multichannel
    import bqmc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CHAN   = 8;
    localparam int SAMPLE_W = 24;
    localparam int PHASES   = 7;
    localparam int PHASE_LEN = 90;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [CFG_W-1:0] REG_SPARE_FIRST = 3'd5;

    localparam longint Y_MAX  = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint Y_MIN  = -Y_MAX - 1;
    localparam longint ST_MAX = (64'sd1 <<< (STATE_W - 1)) - 1;
    localparam longint ST_MIN = -ST_MAX - 1;
    localparam longint HALF_LSB = 64'sd1 <<< (FRAC_W - 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]          chan;
    } t_beat;

    class biquad_tracker;
        logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
        longint r1[N_CHAN];
        longint r2[N_CHAN];
        t_beat  filtered_due[$];
        int     mismatches;

        function new();
            b0 = B0_RESET;
            b1 = '0;
            b2 = '0;
            a1 = '0;
            a2 = '0;
            foreach (r1[i]) begin
                r1[i] = 0;
                r2[i] = 0;
            end
            mismatches = 0;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void set_coef(logic [CFG_W-1:0] idx, logic [COEF_W-1:0] v);
            case (idx)
                REG_B0: b0 = v;
                REG_B1: b1 = v;
                REG_B2: b2 = v;
                REG_A1: a1 = v;
                REG_A2: a2 = v;
                default: ;
            endcase
        endfunction

        // run one accepted sample through the filter and queue its output
        function void take_sample(logic signed [SAMPLE_W-1:0] s, logic [CHAN_W-1:0] c);
            longint x, acc, y;
            t_beat  e;
            x = longint'(s);
            e.chan = c;
            if (int'(c) >= N_CHAN) begin
                e.sample = s;
            end else begin
                acc = longint'(b0) * x + r1[c] + HALF_LSB;
                y = clamp(acc >>> FRAC_W, Y_MIN, Y_MAX);
                r1[c] = clamp(longint'(b1) * x - longint'(a1) * y + r2[c], ST_MIN, ST_MAX);
                r2[c] = clamp(longint'(b2) * x - longint'(a2) * y, ST_MIN, ST_MAX);
                e.sample = y[SAMPLE_W-1:0];
            end
            filtered_due.push_back(e);
        endfunction

        function void check_filtered(logic signed [SAMPLE_W-1:0] s, logic [CHAN_W-1:0] c);
            t_beat e;
            if (filtered_due.size() == 0) begin
                $error("unexpected beat: sample_out %0d chan_out %0d", s, c);
                mismatches++;
                return;
            end
            e = filtered_due.pop_front();
            if (s !== e.sample) begin
                $error("sample_out: expected %0d, got %0d", e.sample, s);
                mismatches++;
            end
            if (c !== e.chan) begin
                $error("chan_out: expected %0d, got %0d", e.chan, c);
                mismatches++;
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [CFG_W-1:0]           i_cfg_index;
    logic [COEF_W-1:0]          i_cfg_data;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample_in;
    logic [CHAN_W-1:0]          i_chan_in;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic [CHAN_W-1:0]          o_chan_out;

    biquad_tracker tracker = new();
    int sent;
    int drained;
    int cycles = 0;

    biquad_tdf2_multichannel #(
        .CHANNELS    (N_CHAN),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample_in  (i_sample_in),
        .i_chan_in    (i_chan_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .o_chan_out   (o_chan_out)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_biquad_tdf2_multichannel: FAIL");
            $finish;
        end
    end

    // all calls start and end on a falling edge
    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [COEF_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        tracker.set_coef(idx, v);
        @(negedge i_clk);
    endtask

    task automatic write_spares();
        for (int k = REG_SPARE_FIRST; k < 2 ** CFG_W; k++)
            write_reg(CFG_W'(k), $urandom());
    endtask

    task automatic load_coefs(input logic [COEF_W-1:0] b0, b1, b2, a1, a2);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        write_spares();
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s,
                               input logic [CHAN_W-1:0] c);
        int gap;
        gap = (sent % 60 < 15) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_in <= s;
        i_chan_in   <= c;
        do @(posedge i_clk); while (!o_ready);
        tracker.take_sample(s, c);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tracker.filtered_due.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
            2: return SAMPLE_W'($urandom_range(0, 255)) - SAMPLE_W'(128);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // receive side: random stalls, bursts of none, and two long hold-offs
    initial begin
        int stall;
        i_ready = 1'b0;
        drained = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (drained == 130 || drained == 430)
                stall = 64;
            else
                stall = (drained % 45 < 10) ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            tracker.check_filtered(o_sample_out, o_chan_out);
            drained++;
            @(negedge i_clk);
        end
    end

    initial begin
        logic signed [SAMPLE_W-1:0] corners[7];
        sent        = 0;
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_sample_in = '0;
        i_chan_in   = '0;
        corners = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF,
                    24'sh000001, 24'sh555555, 24'shAAAAAA};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // junk on unused indexes must not disturb the passthrough default
        write_spares();
        i_cfg_wr_en <= 1'b0;

        for (int i = 0; i < 21; i++)
            send_sample(corners[i % 7], CHAN_W'(i % N_CHAN));

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: load_coefs(32'sd65700, 32'sd131400, 32'sd65700,
                              -32'sd30455800, 32'sd13941600);
                1: load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF);
                2: load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000);
                3: load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                4: load_coefs($urandom_range(0, 2 ** 26) - 2 ** 25,
                              $urandom_range(0, 2 ** 26) - 2 ** 25,
                              $urandom_range(0, 2 ** 26) - 2 ** 25,
                              $urandom_range(0, 2 ** 26) - 2 ** 25,
                              $urandom_range(0, 2 ** 24) - 2 ** 23);
                5: load_coefs('0, '0, '0, '0, '0);
                default: load_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h8000_0000);
            endcase
            for (int i = 0; i < PHASE_LEN; i++)
                send_sample(rand_sample(), CHAN_W'($urandom_range(0, 2 ** CHAN_W - 1)));
        end

        i_valid <= 1'b0;
        while (tracker.filtered_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (tracker.mismatches == 0)
            $display("tb_biquad_tdf2_multichannel: PASS");
        else
            $display("tb_biquad_tdf2_multichannel: FAIL");
        $finish;
    end

endmodule
